// ----- rtl/core/swm_pkg.sv -----
// Shared types and constants for the sliding-window median block.
// No dependencies; imported by the length interface, the cell and the top level.
package swm_pkg;

  // width of the window length register word
  localparam int unsigned CFG_WIDTH = 5;
  // window length after reset, before clamping to the window capacity
  localparam int unsigned LEN_RESET = 5;

  // per-cycle command broadcast from the top level to every cell
  typedef struct packed {
    logic step;   // insert the broadcast sample this cycle
    logic clear;  // refill the window with zeros
  } swm_cmd_t;

endpackage

// ----- rtl/core/swm_if.sv -----
// Valid/ready channel interfaces: sample input, median output, length write.
// Depends on swm_pkg for the length word width.
interface swm_sample_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface swm_median_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink (input valid, input median, output ready);
endinterface

interface swm_cfg_if
  import swm_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_WIDTH-1:0] window_length;

  modport source (output valid, output window_length, input ready);
  modport sink (input valid, input window_length, output ready);
endinterface

// ----- rtl/core/swm_cell.sv -----
// One position of the sorted window: holds a value and its age tag and
// picks its next entry from itself, its neighbors or the new sample.
// Depends on swm_pkg.
module swm_cell
  import swm_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned IDX_W        = 4,
  parameter int unsigned LEN_W        = 5,
  parameter int unsigned CELL_IDX     = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  swm_cmd_t                       cmd_i,
  input  logic signed [SAMPLE_WIDTH-1:0] x_i,
  input  logic        [IDX_W-1:0]        ptr_i,
  input  logic        [IDX_W-1:0]        rm_pos_i,
  input  logic        [LEN_W-1:0]        len_i,
  input  logic signed [SAMPLE_WIDTH-1:0] lo_val_i,
  input  logic        [IDX_W-1:0]        lo_tag_i,
  input  logic                           lo_le_i,
  input  logic signed [SAMPLE_WIDTH-1:0] hi_val_i,
  input  logic        [IDX_W-1:0]        hi_tag_i,
  input  logic                           hi_le_i,
  output logic signed [SAMPLE_WIDTH-1:0] val_o,
  output logic        [IDX_W-1:0]        tag_o,
  output logic                           le_o,
  output logic                           rm_o,
  output logic signed [SAMPLE_WIDTH-1:0] val_next_o
);

  logic signed [SAMPLE_WIDTH-1:0] val_q, val_d;
  logic        [IDX_W-1:0]        tag_q, tag_d;

  logic                           active, is_top, is_bottom;
  logic                           below, lo_below;
  logic signed [SAMPLE_WIDTH-1:0] b_self_val, b_lo_val, pick_val;
  logic        [IDX_W-1:0]        b_self_tag, b_lo_tag, pick_tag;
  logic                           b_self_le, b_lo_le, keep_self;

  assign active    = LEN_W'(CELL_IDX) < len_i;
  assign is_top    = LEN_W'(CELL_IDX + 1) == len_i;
  assign is_bottom = (CELL_IDX == 0);
  assign below     = IDX_W'(CELL_IDX) < rm_pos_i;
  assign lo_below  = IDX_W'(CELL_IDX) <= rm_pos_i;

  assign le_o = (val_q <= x_i);
  assign rm_o = active && (tag_q == ptr_i);

  // entries of the window with the oldest sample taken out
  assign b_self_val = below ? val_q : hi_val_i;
  assign b_self_tag = below ? tag_q : hi_tag_i;
  assign b_self_le  = below ? le_o  : hi_le_i;
  assign b_lo_val   = lo_below ? lo_val_i : val_q;
  assign b_lo_tag   = lo_below ? lo_tag_i : tag_q;
  assign b_lo_le    = lo_below ? lo_le_i  : le_o;

  always_comb begin
    keep_self = !is_top && b_self_le;
    if (keep_self) begin
      pick_val = b_self_val;
      pick_tag = b_self_tag;
    end else if (is_bottom || b_lo_le) begin
      // insertion point: first slot whose entry lies above the sample
      pick_val = x_i;
      pick_tag = ptr_i;
    end else begin
      pick_val = b_lo_val;
      pick_tag = b_lo_tag;
    end
  end

  always_comb begin
    val_d = val_q;
    tag_d = tag_q;
    if (cmd_i.clear) begin
      val_d = '0;
      tag_d = IDX_W'(CELL_IDX);
    end else if (cmd_i.step && active) begin
      val_d = pick_val;
      tag_d = pick_tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      tag_q <= IDX_W'(CELL_IDX);
    end else begin
      val_q <= val_d;
      tag_q <= tag_d;
    end
  end

  assign val_o      = val_q;
  assign tag_o      = tag_q;
  assign val_next_o = val_d;

endmodule

// ----- rtl/core/sliding_window_median_top.sv -----
// Sliding-window median filter: a row of swm_cell positions kept in sorted
// order, the oldest entry replaced by each new sample. Depends on swm_pkg,
// swm_if.sv and swm_cell.
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+-----------------------------------
//  sample_i  | in  | valid / ready | sample, SAMPLE_WIDTH bits signed
//  median_o  | out | valid / ready | median, SAMPLE_WIDTH bits signed
//  cfg_i     | in  | valid / ready | window_length, 5 bits unsigned
//
// One sample per cycle: every cell compares against the new sample and takes
// its next entry from itself or a neighbor in the same cycle; the median is
// registered from the new window contents at the edge that takes the sample word.
// sample_i.ready drops while a finished median waits and median_o.ready is
// low, and while a length word is offered on cfg_i.
// cfg_i is always ready; a length write clears the window.
// Reset clears the window to zeros and sets the length to 5 (capped at WINDOW_MAX).
module sliding_window_median_top
  import swm_pkg::*;
#(
  parameter int unsigned WINDOW_MAX   = 16,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  swm_sample_if.sink   sample_i,
  swm_median_if.source median_o,
  swm_cfg_if.sink      cfg_i
);

  localparam int unsigned IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int unsigned CMP_W = (LEN_W > CFG_WIDTH) ? LEN_W : CFG_WIDTH;
  localparam int unsigned LEN_INIT = (LEN_RESET > WINDOW_MAX) ? WINDOW_MAX : LEN_RESET;

  swm_cmd_t cmd;

  logic [LEN_W-1:0] len_q, len_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [LEN_W-1:0] ptr_inc;
  logic [IDX_W-1:0] rm_pos;
  logic [IDX_W-1:0] mid;
  logic [CMP_W-1:0] cfg_ext;

  logic signed [SAMPLE_WIDTH-1:0] med_q;
  logic                           med_valid_q;

  logic signed [SAMPLE_WIDTH-1:0] val     [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] val_nxt [WINDOW_MAX];
  logic        [IDX_W-1:0]        tag     [WINDOW_MAX];
  logic        [WINDOW_MAX-1:0]   le;
  logic        [WINDOW_MAX-1:0]   rm;

  logic in_fire, out_fire, cfg_fire;

  // hold samples off while a length word is offered
  assign sample_i.ready = (!med_valid_q || median_o.ready) && !cfg_i.valid;
  assign cfg_i.ready    = 1'b1;
  assign in_fire  = sample_i.valid && sample_i.ready;
  assign out_fire = median_o.valid && median_o.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;

  assign cmd = '{step: in_fire && !cfg_fire, clear: cfg_fire};

  // position of the oldest entry: exactly one active cell matches the pointer
  always_comb begin
    rm_pos = '0;
    for (int i = 0; i < int'(WINDOW_MAX); i++) begin
      if (rm[i]) begin
        rm_pos = rm_pos | IDX_W'(i);
      end
    end
  end

  for (genvar g = 0; g < int'(WINDOW_MAX); g++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] lo_val, hi_val;
    logic        [IDX_W-1:0]        lo_tag, hi_tag;
    logic                           lo_le, hi_le;

    if (g == 0) begin : g_bottom
      assign lo_val = '0;
      assign lo_tag = '0;
      assign lo_le  = 1'b0;
    end else begin : g_lo
      assign lo_val = val[g-1];
      assign lo_tag = tag[g-1];
      assign lo_le  = le[g-1];
    end

    if (g == int'(WINDOW_MAX) - 1) begin : g_top
      assign hi_val = '0;
      assign hi_tag = '0;
      assign hi_le  = 1'b0;
    end else begin : g_hi
      assign hi_val = val[g+1];
      assign hi_tag = tag[g+1];
      assign hi_le  = le[g+1];
    end

    swm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .IDX_W        (IDX_W),
      .LEN_W        (LEN_W),
      .CELL_IDX     (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .x_i        (sample_i.sample),
      .ptr_i      (ptr_q),
      .rm_pos_i   (rm_pos),
      .len_i      (len_q),
      .lo_val_i   (lo_val),
      .lo_tag_i   (lo_tag),
      .lo_le_i    (lo_le),
      .hi_val_i   (hi_val),
      .hi_tag_i   (hi_tag),
      .hi_le_i    (hi_le),
      .val_o      (val[g]),
      .tag_o      (tag[g]),
      .le_o       (le[g]),
      .rm_o       (rm[g]),
      .val_next_o (val_nxt[g])
    );
  end

  assign mid     = IDX_W'(len_q >> 1);
  assign ptr_inc = LEN_W'(ptr_q) + LEN_W'(1);
  assign cfg_ext = CMP_W'(cfg_i.window_length);

  always_comb begin
    len_d = len_q;
    ptr_d = ptr_q;
    if (cfg_fire) begin
      // clamp the written length into one to WINDOW_MAX
      priority if (cfg_ext == '0) begin
        len_d = LEN_W'(1);
      end else if (cfg_ext > CMP_W'(WINDOW_MAX)) begin
        len_d = LEN_W'(WINDOW_MAX);
      end else begin
        len_d = LEN_W'(cfg_ext);
      end
      ptr_d = '0;
    end else if (in_fire) begin
      // advance and wrap at the window length
      ptr_d = (ptr_inc >= len_q) ? '0 : IDX_W'(ptr_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= LEN_W'(LEN_INIT);
      ptr_q       <= '0;
      med_valid_q <= 1'b0;
    end else begin
      len_q <= len_d;
      ptr_q <= ptr_d;
      if (cmd.step) begin
        med_valid_q <= 1'b1;
      end else if (out_fire) begin
        med_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.step) begin
      med_q <= val_nxt[mid];
    end
  end

  assign median_o.valid  = med_valid_q;
  assign median_o.median = med_q;

  // a taken sample word always leaves a median word behind
  a_step_gives_median: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |=> med_valid_q)
    else $error("median word missing after sample");

  // a waiting median is held until taken
  a_median_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (med_valid_q && !median_o.ready) |=> (med_valid_q && $stable(med_q)))
    else $error("pending median lost or changed");

  // the pointer stays inside the window
  a_ptr_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LEN_W'(ptr_q) < len_q)
    else $error("oldest pointer outside window");

  // tags of the active window form a permutation: one oldest entry
  a_one_oldest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(rm))
    else $error("oldest entry not unique");

endmodule

// ----- test/sliding_window_median_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench for sliding_window_median_top: directed and random samples, checked
// against a sorted-window median predictor. Depends on swm_pkg and swm_if.sv.
module sliding_window_median_top_tb;
  import swm_pkg::*;

  localparam int unsigned WINDOW_MAX   = 16;
  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned SEG_ITEMS    = 112;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PRINT_LIMIT  = 40;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef enum int {
    MIX_FULL,
    MIX_NARROW,
    MIX_EXTREME,
    MIX_WALK
  } value_mix_e;

  logic clk_i;
  logic rst_ni;

  swm_sample_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) sample_if ();
  swm_median_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) median_if ();
  swm_cfg_if cfg_if ();

  sliding_window_median_top #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_if),
    .median_o(median_if),
    .cfg_i   (cfg_if)
  );

  // predictor state
  sample_t win_vals [WINDOW_MAX];
  int      win_ages [WINDOW_MAX];
  int      oldest_age;
  int      win_len;

  sample_t medians_due [$];
  int      error_count;
  int      cycle_count;
  int      idle_pct;
  int      stall_pct;
  sample_t walk_val;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_LIMIT) $display("tb: mismatch: %s", msg);
    error_count++;
  endtask

  function automatic void clear_window();
    for (int i = 0; i < WINDOW_MAX; i++) begin
      win_vals[i] = '0;
      win_ages[i] = i;
    end
    oldest_age = 0;
  endfunction

  // Replace the oldest entry with x, re-sort it into place, return the median.
  function automatic sample_t predict_median(input sample_t x);
    int pos;
    pos = win_len - 1;
    for (int i = win_len - 1; i >= 0; i--) begin
      if (win_ages[i] == oldest_age) pos = i;
    end
    if (pos + 1 < win_len && win_vals[pos+1] < x) begin
      while (pos + 1 < win_len && win_vals[pos+1] < x) begin
        win_vals[pos] = win_vals[pos+1];
        win_ages[pos] = win_ages[pos+1];
        pos++;
      end
    end else if (pos > 0 && win_vals[pos-1] > x) begin
      while (pos > 0 && win_vals[pos-1] > x) begin
        win_vals[pos] = win_vals[pos-1];
        win_ages[pos] = win_ages[pos-1];
        pos--;
      end
    end
    win_vals[pos] = x;
    win_ages[pos] = oldest_age;
    oldest_age = (oldest_age + 1 >= win_len) ? 0 : oldest_age + 1;
    return win_vals[win_len / 2];
  endfunction

  function automatic sample_t gen_sample(input value_mix_e mix);
    int v;
    case (mix)
      MIX_NARROW: begin
        v = int'($urandom_range(6)) - 3;
        return sample_t'(v);
      end
      MIX_EXTREME: begin
        case ($urandom_range(3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return '0;
          default: return '1;
        endcase
      end
      MIX_WALK: begin
        v = int'($urandom_range(16)) - 8;
        walk_val = walk_val + sample_t'(v);
        return walk_val;
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Leaves valid high on return; the caller sends again or drops it.
  task automatic send_sample(input sample_t value);
    while ($urandom_range(99) < idle_pct) begin
      sample_if.valid  <= 1'b0;
      sample_if.sample <= sample_t'($urandom);
      @(negedge clk_i);
    end
    sample_if.valid  <= 1'b1;
    sample_if.sample <= value;
    do @(posedge clk_i); while (!sample_if.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    sample_if.valid <= 1'b0;
    while (medians_due.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_length(input logic [CFG_WIDTH-1:0] length_word);
    wait_drained();
    repeat (4) @(negedge clk_i);
    cfg_if.valid         <= 1'b1;
    cfg_if.window_length <= length_word;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (length_word == 0) win_len = 1;
    else if (length_word > WINDOW_MAX) win_len = WINDOW_MAX;
    else win_len = length_word;
    clear_window();
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Reset length of five: extremes, signs, and a run of equal values.
  task automatic test_reset_window();
    sample_t vals [$];
    vals = '{16'sh7fff, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1, 16'sd100, 16'sd100,
             16'sd100};
    foreach (vals[i]) send_sample(vals[i]);
    wait_drained();
  endtask

  // Length zero rounds up to one, oversize lengths cap at the window size.
  task automatic test_length_limits();
    write_length(5'd0);
    send_sample(-16'sd5);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    write_length(5'd31);
    send_sample(16'sd3);
    send_sample(-16'sd3);
    send_sample(16'sh7fff);
    write_length(5'd17);
    send_sample(16'sh8000);
    send_sample(16'sd0);
    write_length(5'd2);
    send_sample(16'sd9);
    send_sample(16'sd9);
    send_sample(-16'sd9);
    send_sample(16'sd9);
    write_length(5'd16);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(-16'sd1);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int phase, input int idle, input int stall);
    value_mix_e mix;
    idle_pct  = idle;
    stall_pct = stall;
    for (int seg = 0; seg < 3; seg++) begin
      case (seg)
        0: write_length((phase % 2) ? 5'd16 : 5'd1);
        1: write_length(5'($urandom_range(31)));
        default: write_length(5'($urandom_range(2, 16)));
      endcase
      mix      = value_mix_e'($urandom_range(3));
      walk_val = sample_t'($urandom);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // hold off mid-segment until the pipe is empty
        if (seg == 1 && n == SEG_ITEMS / 2) wait_drained();
        if ($urandom_range(9) == 0) send_sample(gen_sample(MIX_FULL));
        else send_sample(gen_sample(mix));
      end
    end
    wait_drained();
  endtask

  always @(negedge clk_i) begin
    median_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Check the median word first, then queue the prediction for a new sample.
  always @(posedge clk_i) begin
    sample_t exp_median;
    if (rst_ni) begin
      if (median_if.valid && median_if.ready) begin
        if (medians_due.size() == 0) begin
          report_mismatch($sformatf("unexpected median %0d", median_if.median));
        end else begin
          exp_median = medians_due.pop_front();
          if (median_if.median !== exp_median)
            report_mismatch($sformatf("median %0d, expected %0d",
                                      median_if.median, exp_median));
        end
      end
      if (sample_if.valid && sample_if.ready)
        medians_due.push_back(predict_median(sample_if.sample));
    end
  end

  initial begin
    error_count          = 0;
    cycle_count          = 0;
    idle_pct             = 0;
    stall_pct            = 0;
    walk_val             = '0;
    rst_ni               = 1'b0;
    sample_if.valid      = 1'b0;
    sample_if.sample     = '0;
    median_if.ready      = 1'b1;
    cfg_if.valid         = 1'b0;
    cfg_if.window_length = '0;
    win_len              = LEN_RESET;
    clear_window();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_window();
    test_length_limits();
    test_random_traffic(0, 0, 0);
    test_random_traffic(1, 75, 0);
    test_random_traffic(2, 0, 75);
    test_random_traffic(3, 25, 25);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (medians_due.size() != 0)
      report_mismatch($sformatf("%0d medians never arrived", medians_due.size()));
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
